@@ hdl/rwr_pkg.sv @@
// Shared types and constants for the reduced word rank block.
// Used by rwr_step and reduced_word_rank_top; depends on nothing else.
`default_nettype none

package rwr_pkg;

    localparam int LETTER_W = 8;
    localparam int INDEX_W  = 32;
    localparam int CFG_W    = 4;

    localparam logic [LETTER_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [LETTER_W-1:0] ASCII_LOWER_A = 8'd97;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_WRONG_LENGTH = 2'd1,
        ST_BAD_LETTER   = 2'd2,
        ST_OVERFLOW     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_RANK     = 1'b0,
        REG_WORD_LEN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic    is_edge;
        status_t status;
    } rwr_flags_t;

endpackage

`default_nettype wire

@@ hdl/rwr_step.sv @@
// One letter step of the word ranking: letter decode, inverse removal,
// Horner multiply-add with saturation, and the end-of-word result.
// Depends on rwr_pkg.
`default_nettype none

module rwr_step
    import rwr_pkg::*;
#(
    parameter int MAX_RANK = 8,
    parameter int MAX_LEN  = 8,
    localparam int VAL_W   = (2 * MAX_RANK > 1) ? $clog2(2 * MAX_RANK) : 1,
    localparam int RANK_W  = $clog2(MAX_RANK + 1),
    localparam int CNT_W   = $clog2(MAX_LEN + 2)
)
(
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic [RANK_W-1:0]   rank_eff,
    input  wire logic [CNT_W-1:0]    len_eff,
    input  wire logic [INDEX_W-1:0]  acc,
    input  wire logic [VAL_W-1:0]    prev,
    input  wire logic [CNT_W-1:0]    count,
    input  wire status_t             err,
    output logic [INDEX_W-1:0]       acc_next,
    output logic [VAL_W-1:0]         prev_next,
    output logic [CNT_W-1:0]         count_next,
    output status_t                  err_next,
    output logic [INDEX_W-1:0]       index_res,
    output rwr_flags_t               flags_res
);

    localparam int SUM_W = INDEX_W + VAL_W + 1;

    logic [LETTER_W-1:0] off_u;
    logic [LETTER_W-1:0] off_l;
    logic                hit_u;
    logic                hit_l;
    logic [VAL_W-1:0]    r_v;
    logic [VAL_W-1:0]    val;
    logic [VAL_W-1:0]    removed;
    logic [VAL_W-1:0]    digit;
    logic [VAL_W-1:0]    base;
    logic [SUM_W-1:0]    nxt;
    logic                ovf;
    logic                len_edge;
    logic                len_vert;

    // Letter decode: upper case maps to 0..r-1, lower case to r..2r-1
    always_comb
    begin
        r_v   = VAL_W'(rank_eff);
        off_u = letter - ASCII_UPPER_A;
        off_l = letter - ASCII_LOWER_A;
        hit_u = (letter >= ASCII_UPPER_A) && (off_u < LETTER_W'(rank_eff));
        hit_l = (letter >= ASCII_LOWER_A) && (off_l < LETTER_W'(rank_eff));
        val   = hit_u ? off_u[VAL_W-1:0] : (r_v + off_l[VAL_W-1:0]);
    end

    // Drop the inverse of the previous letter from the alphabet
    always_comb
    begin
        removed = (prev < r_v) ? (prev + r_v) : (prev - r_v);
        digit   = (val > removed) ? (val - VAL_W'(1)) : val;
        base    = r_v + r_v - VAL_W'(1);
        nxt     = SUM_W'(acc) * SUM_W'(base) + SUM_W'(digit);
        ovf     = |nxt[SUM_W-1:INDEX_W];
    end

    always_comb
    begin
        acc_next  = acc;
        prev_next = prev;
        err_next  = err;
        if (!(hit_u || hit_l))
        begin
            err_next = ST_BAD_LETTER;
        end
        else if (count == '0)
        begin
            acc_next  = INDEX_W'(val);
            prev_next = val;
        end
        else
        begin
            if (val == removed)
            begin
                err_next = ST_BAD_LETTER;
            end
            else if (err == ST_OVERFLOW || ovf)
            begin
                // saturate and hold for the rest of the word
                acc_next = '1;
                if (err == ST_OK)
                begin
                    err_next = ST_OVERFLOW;
                end
            end
            else
            begin
                acc_next = nxt[INDEX_W-1:0];
            end
            prev_next = val;
        end
        count_next = (count < CNT_W'(MAX_LEN + 1)) ? (count + CNT_W'(1)) : count;
    end

    // End-of-word result from the updated state
    always_comb
    begin
        len_edge  = (count_next == len_eff);
        len_vert  = (count_next == (len_eff - CNT_W'(1)));
        index_res = '0;
        flags_res.is_edge = len_edge;
        if (!(len_edge || len_vert))
        begin
            flags_res.status  = ST_WRONG_LENGTH;
            flags_res.is_edge = 1'b0;
        end
        else if (err_next == ST_BAD_LETTER)
        begin
            flags_res.status = ST_BAD_LETTER;
        end
        else
        begin
            flags_res.status = err_next;
            index_res        = acc_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/reduced_word_rank_top.sv @@
// Top level of the reduced word rank block: configuration registers,
// input register, word state and result register. Depends on rwr_pkg, rwr_step.
`default_nettype none

// Takes one ASCII letter per cycle and returns the dense index of the reduced
// word on the letter marked last. The letter is held in the input register, and the
// result register loads when the held last letter advances, so the result is
// presented from the result register after the last letter has left the input
// register. A new letter is accepted every cycle unless the held letter is last
// and the result register holds a result that is stalled. The combinational Horner
// step, a 32-bit by small-base multiply-add on the word accumulator, sets that rate.
// Status is ok, wrong_length, bad_letter or overflow (index saturated at all ones).
// rank and word_len may be written only while no word is in flight.
module reduced_word_rank_top
    import rwr_pkg::*;
#(
    parameter int MAX_RANK = 8,
    parameter int MAX_LEN  = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_idx,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic                last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [INDEX_W-1:0]       index,
    output logic                     is_edge,
    output logic [1:0]               status
);

    localparam int VAL_W  = (2 * MAX_RANK > 1) ? $clog2(2 * MAX_RANK) : 1;
    localparam int RANK_W = $clog2(MAX_RANK + 1);
    localparam int CNT_W  = $clog2(MAX_LEN + 2);

    logic [CFG_W-1:0]    rank_reg;
    logic [CFG_W-1:0]    word_len_reg;
    logic [CFG_W-1:0]    rank_clamp;
    logic [CFG_W-1:0]    len_clamp;

    logic                in_valid_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                last_reg;

    logic [INDEX_W-1:0]  acc_reg;
    logic [VAL_W-1:0]    prev_reg;
    logic [CNT_W-1:0]    count_reg;
    status_t             err_reg;

    logic [INDEX_W-1:0]  acc_next;
    logic [VAL_W-1:0]    prev_next;
    logic [CNT_W-1:0]    count_next;
    status_t             err_next;
    logic [INDEX_W-1:0]  index_res;
    rwr_flags_t          flags_res;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  index_reg;
    rwr_flags_t          flags_reg;

    logic                advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg     <= CFG_W'(2);
            word_len_reg <= CFG_W'(4);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_RANK:     rank_reg     <= cfg_data;
                REG_WORD_LEN: word_len_reg <= cfg_data;
                default:      rank_reg     <= rank_reg;
            endcase
        end
    end

    // Clamp out-of-range settings
    always_comb
    begin
        if (rank_reg == '0)
            rank_clamp = CFG_W'(1);
        else if (rank_reg > CFG_W'(MAX_RANK))
            rank_clamp = CFG_W'(MAX_RANK);
        else
            rank_clamp = rank_reg;

        if (word_len_reg < CFG_W'(2))
            len_clamp = CFG_W'(2);
        else if (word_len_reg > CFG_W'(MAX_LEN))
            len_clamp = CFG_W'(MAX_LEN);
        else
            len_clamp = word_len_reg;
    end

    // The held letter advances unless it is last and the result slot is full and stalled
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            letter_reg <= letter;
            last_reg   <= last;
        end
    end

    rwr_step #(
        .MAX_RANK (MAX_RANK),
        .MAX_LEN  (MAX_LEN)
    ) u_step (
        .letter     (letter_reg),
        .rank_eff   (RANK_W'(rank_clamp)),
        .len_eff    (CNT_W'(len_clamp)),
        .acc        (acc_reg),
        .prev       (prev_reg),
        .count      (count_reg),
        .err        (err_reg),
        .acc_next   (acc_next),
        .prev_next  (prev_next),
        .count_next (count_next),
        .err_next   (err_next),
        .index_res  (index_res),
        .flags_res  (flags_res)
    );

    // Word state; clear after the last letter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            prev_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                acc_reg   <= '0;
                prev_reg  <= '0;
                count_reg <= '0;
                err_reg   <= ST_OK;
            end
            else
            begin
                acc_reg   <= acc_next;
                prev_reg  <= prev_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            index_reg <= index_res;
            flags_reg <= flags_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign index     = index_reg;
    assign is_edge   = flags_reg.is_edge;
    assign status    = flags_reg.status;

    a_clear_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> count_reg == '0 && err_reg == ST_OK && acc_reg == '0)
        else $error("word state not cleared after last letter");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN + 1))
        else $error("letter count beyond its limit");

    a_overflow_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == ST_OVERFLOW |-> &acc_reg)
        else $error("overflow flagged without saturated accumulator");

    a_wrong_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_WRONG_LENGTH |-> index == '0 && !is_edge)
        else $error("wrong length result carries index or edge");

endmodule

`default_nettype wire

@@ tb/sv/reduced_word_rank_top_tb.sv @@
// Self-checking testbench for reduced_word_rank_top: directed rows, then random words.
// Results are checked against an in-bench ranking model of the word accumulator, or against the expected value
// given with a directed row. Depends on rwr_pkg and the reduced_word_rank_top RTL.
module reduced_word_rank_top_tb;
    import rwr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RANK      = 8;
    localparam int MAX_LEN       = 8;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 4;
    // stall bursts and send gaps are bounded by the random ranges drawn below, so this is far beyond
    // any legitimate stretch without a transaction
    localparam int STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               is_edge;
        status_t            status;
    } rank_result_t;

    typedef struct packed {
        logic         has_exp;
        rank_result_t exp;
    } letter_hint_t;

    typedef enum logic {
        ROW_LETTER,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [LETTER_W-1:0] ch;
        logic             lst;
        logic [CFG_W-1:0] rank_val;
        logic [CFG_W-1:0] len_val;
        letter_hint_t     hint;
    } directed_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we = 1'b0;
    logic [0:0]          cfg_idx = REG_RANK;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [LETTER_W-1:0] letter = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [INDEX_W-1:0]  index;
    logic                is_edge;
    logic [1:0]          status;

    // model copy of the registers and the word state
    logic [CFG_W-1:0]    rank_reg = 4'd2;
    logic [CFG_W-1:0]    len_reg = 4'd4;
    logic [INDEX_W-1:0]  acc_q = '0;
    logic [3:0]          prev_letter = '0;
    logic [3:0]          count_q = '0;
    status_t             word_err = ST_OK;

    rank_result_t        expected_ranks[$];
    letter_hint_t        letter_hints[$];
    directed_row_t       directed_rows[$];

    int                  fail_count = 0;
    int                  stuck_cycles = 0;
    int                  items_sent = 0;
    int                  stall_left = 0;
    bit                  steady = 1'b0;

    reduced_word_rank_top #(
        .MAX_RANK (MAX_RANK),
        .MAX_LEN  (MAX_LEN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .letter    (letter),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .index     (index),
        .is_edge   (is_edge),
        .status    (status)
    );

    always #4 clk = ~clk;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [LETTER_W-1:0] letter_of(input int v, input int r);
        if (v < r)
            return LETTER_W'(ASCII_UPPER_A + v);
        return LETTER_W'(ASCII_LOWER_A + (v - r));
    endfunction

    // Advance the word state by one letter; returns 1 when the letter closes a word.
    function automatic bit rank_letter(input logic [LETTER_W-1:0] ch, input logic lst,
                                       output rank_result_t res);
        int          r;
        int          wl;
        int          c;
        int          ua;
        int          la;
        int          v;
        int          removed;
        int          digit;
        logic [63:0] nxt;
        r  = clamp(rank_reg, 1, MAX_RANK);
        wl = clamp(len_reg, 2, MAX_LEN);
        c  = ch;
        ua = ASCII_UPPER_A;
        la = ASCII_LOWER_A;
        res = '0;
        if (c >= ua && c < ua + r)
            v = c - ua;
        else if (c >= la && c < la + r)
            v = r + c - la;
        else
            v = -1;

        if (v < 0)
        begin
            word_err = ST_BAD_LETTER;
        end
        else if (count_q == 0)
        begin
            acc_q       = INDEX_W'(v);
            prev_letter = 4'(v);
        end
        else
        begin
            // the inverse of the previous letter is dropped from the alphabet
            removed = (prev_letter < r) ? prev_letter + r : prev_letter - r;
            if (v == removed)
            begin
                word_err = ST_BAD_LETTER;
            end
            else
            begin
                digit = (v > removed) ? v - 1 : v;
                nxt = 64'(acc_q) * 64'(2 * r - 1) + 64'(digit);
                if (word_err == ST_OVERFLOW || nxt > 64'hFFFF_FFFF)
                begin
                    acc_q = '1;
                    if (word_err == ST_OK)
                        word_err = ST_OVERFLOW;
                end
                else
                begin
                    acc_q = nxt[31:0];
                end
            end
            prev_letter = 4'(v);
        end
        if (count_q < MAX_LEN + 1)
            count_q++;

        if (!lst)
            return 1'b0;

        res.is_edge = (count_q == wl);
        if (count_q != wl && count_q != wl - 1)
        begin
            res.status  = ST_WRONG_LENGTH;
            res.is_edge = 1'b0;
        end
        else if (word_err == ST_BAD_LETTER)
        begin
            res.status = ST_BAD_LETTER;
        end
        else
        begin
            res.status = word_err;
            res.index  = acc_q;
        end
        acc_q       = '0;
        prev_letter = '0;
        count_q     = '0;
        word_err    = ST_OK;
        return 1'b1;
    endfunction

    task automatic add_letter(input logic [LETTER_W-1:0] ch, input logic lst);
        directed_row_t row;
        row      = '0;
        row.kind = ROW_LETTER;
        row.ch   = ch;
        row.lst  = lst;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_typed(input logic [LETTER_W-1:0] ch, input logic [INDEX_W-1:0] idx,
                             input logic edge_bit, input status_t st);
        directed_row_t row;
        row                     = '0;
        row.kind                = ROW_LETTER;
        row.ch                  = ch;
        row.lst                 = 1'b1;
        row.hint.has_exp        = 1'b1;
        row.hint.exp.index      = idx;
        row.hint.exp.is_edge    = edge_bit;
        row.hint.exp.status     = st;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_config(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] l);
        directed_row_t row;
        row          = '0;
        row.kind     = ROW_CONFIG;
        row.rank_val = r;
        row.len_val  = l;
        directed_rows = {directed_rows, row};
    endtask

    // Present one letter and hold it until the transaction completes.
    task automatic send_letter(input logic [LETTER_W-1:0] ch, input logic lst,
                               input letter_hint_t hint);
        letter_hints = {letter_hints, hint};
        in_valid <= 1'b1;
        letter   <= ch;
        last     <= lst;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        if (!steady && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drain every pending result, let the pipeline empty, then write both registers.
    task automatic reconfigure(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] l);
        in_valid <= 1'b0;
        // let the monitor record the last accepted letter first
        @(posedge clk);
        while (expected_ranks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_RANK;
        cfg_data <= r;
        @(posedge clk);
        rank_reg = r;
        cfg_idx  <= REG_WORD_LEN;
        cfg_data <= l;
        @(posedge clk);
        len_reg = l;
        cfg_we   <= 1'b0;
    endtask

    task automatic send_random_word(input int r, input int l);
        int                  mode;
        int                  n;
        int                  i;
        int                  v;
        int                  prev_v;
        int                  inv;
        bit                  noisy;
        logic [LETTER_W-1:0] ch;
        mode   = $urandom_range(0, 19);
        noisy  = (mode >= 17);
        prev_v = 0;
        if (mode == 15 || mode == 16)
            n = $urandom_range(1, MAX_LEN + 3);
        else
            n = ($urandom_range(0, 1) == 1) ? l : l - 1;
        for (i = 0; i < n; i++)
        begin
            inv = (prev_v < r) ? prev_v + r : prev_v - r;
            if (i == 0)
            begin
                v = (mode == 14) ? 2 * r - 1 : $urandom_range(0, 2 * r - 1);
            end
            else if (mode == 14)
            begin
                // largest digit allowed after the previous letter
                v = (inv == 2 * r - 1) ? 2 * r - 2 : 2 * r - 1;
            end
            else
            begin
                v = $urandom_range(0, 2 * r - 2);
                if (v >= inv)
                    v++;
            end
            ch = letter_of(v, r);
            if (noisy && $urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = LETTER_W'($urandom_range(0, 255));
                    1:       ch = letter_of(inv, r);
                    2:       ch = LETTER_W'(ASCII_UPPER_A + r);
                    default: ch = LETTER_W'(ASCII_LOWER_A + r);
                endcase
            end
            prev_v = v;
            send_letter(ch, i == n - 1, '0);
        end
    endtask

    // random output stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 1)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 12);
            out_stall  <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        rank_result_t want;
        rank_result_t pred;
        rank_result_t got;
        letter_hint_t hint;
        bit           moved;
        moved = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                moved = 1'b1;
                if (expected_ranks.size() == 0)
                begin
                    $error("unexpected result transaction: index %0d is_edge %0d status %0d",
                           index, is_edge, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_ranks.pop_front();
                    if (index !== want.index)
                    begin
                        $error("index: expected %0d, actual %0d", want.index, index);
                        fail_count++;
                    end
                    if (is_edge !== want.is_edge)
                    begin
                        $error("is_edge: expected %0d, actual %0d", want.is_edge, is_edge);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                moved = 1'b1;
                hint = letter_hints.pop_front();
                if (rank_letter(letter, last, pred))
                begin
                    got = hint.has_exp ? hint.exp : pred;
                    expected_ranks = {expected_ranks, got};
                end
            end
            stuck_cycles <= moved ? 0 : stuck_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int               random_start;
        int               phase_end;
        int               eff_r;
        int               eff_l;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] l;
        rst_n = 1'b0;

        // reset values: rank 2, edge length 4
        add_typed("A", 0, 1'b0, ST_WRONG_LENGTH);
        add_letter("A", 1'b0);
        add_letter("A", 1'b0);
        add_typed("A", 0, 1'b0, ST_OK);
        add_letter("b", 1'b0);
        add_letter("b", 1'b0);
        add_letter("b", 1'b0);
        add_typed("b", 107, 1'b1, ST_OK);
        add_letter("A", 1'b0);
        add_letter("a", 1'b0);
        add_typed("B", 0, 1'b0, ST_BAD_LETTER);
        add_letter(8'hFF, 1'b0);
        add_letter("A", 1'b0);
        add_letter(8'h00, 1'b1);
        // rank 0 and length 1 act as rank 1 and length 2
        add_config(4'd0, 4'd1);
        add_letter("a", 1'b0);
        add_typed("a", 1, 1'b1, ST_OK);
        add_typed("A", 0, 1'b0, ST_OK);
        // both registers at all ones clamp to the maximum rank and length
        add_config(4'd15, 4'd15);
        repeat (7) add_letter("h", 1'b0);
        add_typed("h", 32'd2733749999, 1'b1, ST_OK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CONFIG)
                reconfigure(directed_rows[k].rank_val, directed_rows[k].len_val);
            else
                send_letter(directed_rows[k].ch, directed_rows[k].lst, directed_rows[k].hint);
        end

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       r = 4'd1;
                1:       r = CFG_W'(MAX_RANK);
                2:       r = 4'd0;
                3:       r = 4'd15;
                default: r = CFG_W'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 5))
                0:       l = 4'd2;
                1:       l = CFG_W'(MAX_LEN);
                2:       l = CFG_W'($urandom_range(0, 1));
                3:       l = 4'd15;
                default: l = CFG_W'($urandom_range(0, 15));
            endcase
            reconfigure(r, l);
            // the closing stretch runs without any idling
            if (RANDOM_ITEMS - (items_sent - random_start) <= 250)
            begin
                steady    = 1'b1;
                phase_end = random_start + RANDOM_ITEMS;
            end
            else
            begin
                steady    = ($urandom_range(0, 3) == 0);
                phase_end = items_sent + $urandom_range(100, 200);
            end
            eff_r = clamp(r, 1, MAX_RANK);
            eff_l = clamp(l, 2, MAX_LEN);
            while (items_sent < phase_end)
                send_random_word(eff_r, eff_l);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_ranks.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
